/* src/sswq_pkg.sv */
// shared types and constants of the sorted sleep/wakeup queue
package sswq_pkg;

  localparam int unsigned ID_W        = 8;
  localparam int unsigned TICKS_W     = 32;
  localparam int unsigned TIME_W      = 48;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned NW          = $clog2(MAX_RESULTS + 1);

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic REQ_SLEEP = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_WOKEN    = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK_CHK,
    S_SLEEP_CHK,
    S_SLEEP_PUT,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0] wake;
    logic [ID_W-1:0]   thread;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

/* src/sswq_ifs.sv */
// request and result channel interfaces of the sorted sleep/wakeup queue
interface sswq_req_if import sswq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [ID_W-1:0]    thread_id;
  logic [TICKS_W-1:0] sleep_ticks;

  modport source (output valid, req_type, thread_id, sleep_ticks, input ready);
  modport sink   (input valid, req_type, thread_id, sleep_ticks, output ready);
endinterface

interface sswq_res_if import sswq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     woken_id;
  logic                last;

  modport source (output valid, status, woken_id, last, input ready);
  modport sink   (input valid, status, woken_id, last, output ready);
endinterface

/* src/sswq_ram.sv */
// generic simple dual-port ram with registered read
module sswq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/sorted_sleep_wakeup_queue.sv */
// top level: wakeup queue sorted by wake time, kept in a circular buffer in ram
// The block takes one request at a time. Entries live in a ring buffer in one
// ram with a registered read, oldest-due at the head. A tick first bumps the
// tick count, then reads the head and hands over each due thread in turn (at
// most sixteen per tick), marking the last result. A sleep request walks back
// from the tail, moving each later entry up by one slot per cycle, stops at an
// entry with an earlier or equal wake time and writes the new entry into the
// freed slot; a request turned away by a full queue gets a full status. A
// request is taken while a result still waits on the output register; the
// block stalls only when it has a further result to give and the output is
// still occupied.
module sorted_sleep_wakeup_queue import sswq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sswq_req_if.sink     req_i,
  sswq_res_if.source   res_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // logical queue position to ram address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [AW-1:0] k);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, k};
    if (s >= (AW+1)'(QUEUE_DEPTH)) begin
      s = s - (AW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     head_q, head_d;
  logic [TIME_W-1:0] tick_now_q, tick_now_d;
  logic [NW-1:0]     n_q, n_d;
  logic              pend_valid_q, pend_valid_d;
  logic              out_valid_q, out_valid_d;

  logic [AW-1:0]     hole_q, hole_d;
  logic [TIME_W-1:0] wake_q, wake_d;
  status_e           res_status_q, res_status_d;
  logic [ID_W-1:0]   res_id_q, res_id_d;
  status_e           out_status_q, out_status_d;
  logic [ID_W-1:0]   out_id_q, out_id_d;
  logic              out_last_q, out_last_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  entry_t            ram_wdata, ram_rdata;

  logic              can_emit, emit, emit_last;
  status_e           emit_status;
  logic [ID_W-1:0]   emit_id;
  logic [TIME_W:0]   wake_sum;
  logic [TIME_W-1:0] wake_calc;
  logic [AW-1:0]     head_inc;
  logic              due;

  sswq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign can_emit  = !out_valid_q || res_o.ready;
  assign wake_sum  = {1'b0, tick_now_q} + (TIME_W+1)'(req_i.sleep_ticks);
  assign wake_calc = wake_sum[TIME_W] ? TIME_MAX : wake_sum[TIME_W-1:0];
  assign head_inc  = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign due       = ram_rdata.wake <= tick_now_q;

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    head_d       = head_q;
    tick_now_d   = tick_now_q;
    n_d          = n_q;
    pend_valid_d = pend_valid_q;
    hole_d       = hole_q;
    wake_d       = wake_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    emit         = 1'b0;
    emit_status  = ST_WOKEN;
    emit_id      = res_id_q;
    emit_last    = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          if (req_i.req_type == REQ_TICK) begin
            if (tick_now_q != TIME_MAX) begin
              tick_now_d = tick_now_q + TIME_W'(1);
            end
            n_d          = '0;
            pend_valid_d = 1'b0;
            if (count_q != '0) begin
              ram_re    = 1'b1;
              ram_raddr = head_q;
              state_d   = S_TICK_CHK;
            end
          end else begin
            res_id_d     = req_i.thread_id;
            wake_d       = wake_calc;
            res_status_d = ST_ACCEPTED;
            if (count_q == CW'(QUEUE_DEPTH)) begin
              res_status_d = ST_FULL;
              state_d      = S_EMIT;
            end else if (count_q == '0) begin
              hole_d  = '0;
              state_d = S_SLEEP_PUT;
            end else begin
              // hole starts at the tail, compare against the entry before it
              hole_d    = count_q[AW-1:0];
              ram_re    = 1'b1;
              ram_raddr = phys(head_q, count_q[AW-1:0] - AW'(1));
              state_d   = S_SLEEP_CHK;
            end
          end
        end
      end

      S_TICK_CHK: begin
        // the held result goes out once we know whether another follows
        if (!(pend_valid_q && !can_emit)) begin
          if (pend_valid_q) begin
            emit        = 1'b1;
            emit_status = ST_WOKEN;
            emit_id     = res_id_q;
            emit_last   = !due;
          end
          if (due) begin
            res_id_d     = ram_rdata.thread;
            res_status_d = ST_WOKEN;
            pend_valid_d = 1'b1;
            head_d       = head_inc;
            count_d      = count_q - CW'(1);
            n_d          = n_q + NW'(1);
            if ((n_q + NW'(1) == NW'(MAX_RESULTS)) || (count_q == CW'(1))) begin
              pend_valid_d = 1'b0;
              state_d      = S_EMIT;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head_inc;
            end
          end else begin
            pend_valid_d = 1'b0;
            state_d      = S_IDLE;
          end
        end
      end

      S_SLEEP_CHK: begin
        if (ram_rdata.wake > wake_q) begin
          ram_we    = 1'b1;
          ram_waddr = phys(head_q, hole_q);
          ram_wdata = ram_rdata;
          hole_d    = hole_q - AW'(1);
          if (hole_q == AW'(1)) begin
            state_d = S_SLEEP_PUT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = phys(head_q, hole_q - AW'(2));
          end
        end else begin
          state_d = S_SLEEP_PUT;
        end
      end

      S_SLEEP_PUT: begin
        ram_we         = 1'b1;
        ram_waddr      = phys(head_q, hole_q);
        ram_wdata.wake = wake_q;
        ram_wdata.thread = res_id_q;
        count_d        = count_q + CW'(1);
        state_d        = S_EMIT;
      end

      S_EMIT: begin
        if (can_emit) begin
          emit        = 1'b1;
          emit_status = res_status_q;
          emit_id     = res_id_q;
          emit_last   = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register: a new result replaces one that is being transferred
  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    out_last_d   = out_last_q;
    if (emit) begin
      out_valid_d  = 1'b1;
      out_status_d = emit_status;
      out_id_d     = emit_id;
      out_last_d   = emit_last;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      head_q       <= '0;
      tick_now_q   <= '0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      head_q       <= head_d;
      tick_now_q   <= tick_now_d;
      n_q          <= n_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hole_q       <= hole_d;
    wake_q       <= wake_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
    out_last_q   <= out_last_d;
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.status   = out_status_q;
  assign res_o.woken_id = out_id_q;
  assign res_o.last     = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(MAX_RESULTS))
    else $error("too many wakeups in one tick");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SLEEP_PUT) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SLEEP_CHK) |-> (hole_q != '0))
    else $error("shift walk ran past the head");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TICK_CHK) |-> (count_q != '0))
    else $error("wakeup scan on an empty queue");

endmodule
